@@ rtl/ccp_pkg.sv @@
// ----------------------------------------------------------------------------
// ccp_pkg
// Shared types and constants of the conic curve plotter.
// ----------------------------------------------------------------------------
package ccp_pkg;

  localparam int CW   = 32;  // coefficient width, Q16.16
  localparam int TW   = 12;  // swept coordinate
  localparam int DIMW = 13;  // image dimension register
  localparam int BW   = 45;  // linear term b
  localparam int CCW  = 58;  // constant term c
  localparam int DW   = 96;  // discriminant arithmetic
  localparam int SQW  = 95;  // discriminant magnitude and sqrt remainder
  localparam int SRW  = 47;  // square root result
  localparam int NW   = 51;  // rounding numerator
  localparam int DVW  = 34;  // rounding denominator
  localparam int ROW  = 14;  // root field
  localparam int IDXW = 4;   // configuration index

  localparam logic [IDXW-1:0] REG_COEF_XX  = 4'd0;
  localparam logic [IDXW-1:0] REG_COEF_XY  = 4'd1;
  localparam logic [IDXW-1:0] REG_COEF_YY  = 4'd2;
  localparam logic [IDXW-1:0] REG_COEF_X   = 4'd3;
  localparam logic [IDXW-1:0] REG_COEF_Y   = 4'd4;
  localparam logic [IDXW-1:0] REG_COEF_C   = 4'd5;
  localparam logic [IDXW-1:0] REG_WIDTH    = 4'd6;
  localparam logic [IDXW-1:0] REG_HEIGHT   = 4'd7;

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_NEG_DISC  = 2'd1,
    ST_ZERO_LEAD = 2'd2
  } status_t;

  typedef struct packed {
    logic                 op;
    logic [TW-1:0]        coord;
    logic [7:0]           color;
    logic                 lead_zero;
    logic                 disc_neg;
    logic signed [BW-1:0] b;
    logic signed [CW-1:0] lead;
    logic [DIMW-1:0]      side;
  } sband_t;

  typedef struct packed {
    logic                  pass_out;
    logic [TW-1:0]         coord_out;
    logic [7:0]            color_out;
    logic signed [ROW-1:0] root_low;
    logic signed [ROW-1:0] root_high;
    logic [5:0]            write_mask;
    logic [1:0]            status;
  } result_t;

endpackage

@@ rtl/ccp_cfg_if.sv @@
// ----------------------------------------------------------------------------
// ccp_cfg_if
// Register write channel: index and data.
// ----------------------------------------------------------------------------
interface ccp_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/ccp_req_if.sv @@
// ----------------------------------------------------------------------------
// ccp_req_if
// Sweep request channel.
// ----------------------------------------------------------------------------
interface ccp_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [11:0] coord;
  logic [7:0]  pen_color;

  modport source (output valid, op, coord, pen_color, input ready);
  modport sink (input valid, op, coord, pen_color, output ready);
endinterface

@@ rtl/ccp_res_if.sv @@
// ----------------------------------------------------------------------------
// ccp_res_if
// Root result channel.
// ----------------------------------------------------------------------------
interface ccp_res_if;
  logic        valid;
  logic        ready;
  logic        pass_out;
  logic [11:0] coord_out;
  logic [7:0]  color_out;
  logic [13:0] root_low;
  logic [13:0] root_high;
  logic [5:0]  write_mask;
  logic [1:0]  status;

  modport source (output valid, pass_out, coord_out, color_out, root_low, root_high,
                  write_mask, status, input ready);
  modport sink (input valid, pass_out, coord_out, color_out, root_low, root_high,
                write_mask, status, output ready);
endinterface

@@ rtl/ccp_front.sv @@
// ----------------------------------------------------------------------------
// ccp_front
// Quadratic set-up: b, c and the exact discriminant, eight stages.
// ----------------------------------------------------------------------------
module ccp_front #(
  parameter int MAX_SIDE = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_v,
  input  logic                            op,
  input  logic [ccp_pkg::TW-1:0]          coord,
  input  logic [7:0]                      color,
  input  logic signed [ccp_pkg::CW-1:0]   coef_xx,
  input  logic signed [ccp_pkg::CW-1:0]   coef_xy,
  input  logic signed [ccp_pkg::CW-1:0]   coef_yy,
  input  logic signed [ccp_pkg::CW-1:0]   coef_x,
  input  logic signed [ccp_pkg::CW-1:0]   coef_y,
  input  logic signed [ccp_pkg::CW-1:0]   coef_const,
  input  logic [ccp_pkg::DIMW-1:0]        image_width,
  input  logic [ccp_pkg::DIMW-1:0]        image_height,
  output logic                            out_v,
  output ccp_pkg::sband_t                 out_sb,
  output logic [ccp_pkg::SQW-1:0]         out_disc
);
  import ccp_pkg::*;

  typedef struct packed {
    logic                 op;
    logic [TW-1:0]        t;
    logic [7:0]           color;
    logic signed [CW-1:0] lead;
    logic [DIMW-1:0]      side;
  } ctx_t;

  ctx_t                   ctx [8];
  logic [7:0]             v;
  logic [DIMW-1:0]        dim_sel;
  logic signed [CW-1:0]   oth1, lu1, lt1, lu2, lt2;
  logic signed [BW-1:0]   bt2, ot2, b3, ct3, b4, b5, b6, b7, b8;
  logic signed [CCW-1:0]  ctt4, c5;
  logic signed [43:0]     bhh6;
  logic signed [45:0]     bhl6;
  logic [45:0]            bll6;
  logic signed [61:0]     lcl6;
  logic signed [60:0]     lch6;
  logic signed [DW-1:0]   bb7, lc7, disc8;

  assign dim_sel = op ? image_width : image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[6:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctx[0].op    <= op;
      ctx[0].t     <= coord;
      ctx[0].color <= color;
      ctx[0].lead  <= op ? coef_xx : coef_yy;
      ctx[0].side  <= (32'(dim_sel) > MAX_SIDE) ? DIMW'(MAX_SIDE) : dim_sel;
      oth1 <= op ? coef_yy : coef_xx;
      lu1  <= op ? coef_x : coef_y;
      lt1  <= op ? coef_y : coef_x;
      for (int k = 1; k < 8; k++) ctx[k] <= ctx[k-1];

      bt2 <= BW'(coef_xy) * BW'($signed({1'b0, ctx[0].t}));
      ot2 <= BW'(oth1) * BW'($signed({1'b0, ctx[0].t}));
      lu2 <= lu1;
      lt2 <= lt1;

      b3  <= BW'(lu2) + bt2;
      ct3 <= BW'(lt2) + ot2;

      b4   <= b3;
      ctt4 <= CCW'(ct3) * CCW'($signed({1'b0, ctx[2].t}));

      b5 <= b4;
      c5 <= ctt4 + CCW'(coef_const);

      b6   <= b5;
      bhh6 <= 44'($signed(b5[44:23])) * 44'($signed(b5[44:23]));
      bhl6 <= 46'($signed(b5[44:23])) * 46'($signed({1'b0, b5[22:0]}));
      bll6 <= 46'(b5[22:0]) * 46'(b5[22:0]);
      lcl6 <= 62'(ctx[4].lead) * 62'($signed({1'b0, c5[28:0]}));
      lch6 <= 61'(ctx[4].lead) * 61'($signed(c5[57:29]));

      b7  <= b6;
      bb7 <= (DW'(bhh6) <<< 46) + (DW'(bhl6) <<< 24) + $signed(DW'(bll6));
      lc7 <= (DW'(lch6) <<< 29) + DW'(lcl6);

      b8    <= b7;
      disc8 <= bb7 - (lc7 <<< 2);
    end
  end

  always_comb begin
    out_sb.op        = ctx[7].op;
    out_sb.coord     = ctx[7].t;
    out_sb.color     = ctx[7].color;
    out_sb.lead_zero = (ctx[7].lead == '0);
    out_sb.disc_neg  = disc8[DW-1];
    out_sb.b         = b8;
    out_sb.lead      = ctx[7].lead;
    out_sb.side      = ctx[7].side;
  end

  assign out_v    = v[7];
  assign out_disc = disc8[SQW-1:0];

endmodule

@@ rtl/ccp_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// ccp_sqrt_cell
// One bit of the restoring integer square root.
// ----------------------------------------------------------------------------
module ccp_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      v_in,
  input  ccp_pkg::sband_t           sb_in,
  input  logic [ccp_pkg::SQW-1:0]   rem_in,
  input  logic [ccp_pkg::SRW-1:0]   q_in,
  output logic                      v_out,
  output ccp_pkg::sband_t           sb_out,
  output logic [ccp_pkg::SQW-1:0]   rem_out,
  output logic [ccp_pkg::SRW-1:0]   q_out
);
  import ccp_pkg::*;

  logic [SQW-1:0] trial;
  logic           fit;

  // (q + 2^BIT)^2 - q^2 = q*2^(BIT+1) + 2^(2*BIT)
  assign trial = (SQW'(q_in) << (BIT + 1)) | (SQW'(1) << (2 * BIT));
  assign fit   = (rem_in >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_out  <= sb_in;
      rem_out <= fit ? rem_in - trial : rem_in;
      q_out   <= fit ? (q_in | (SRW'(1) << BIT)) : q_in;
    end
  end

endmodule

@@ rtl/ccp_div_cell.sv @@
// ----------------------------------------------------------------------------
// ccp_div_cell
// One quotient bit of the rounding divide, both roots side by side.
// ----------------------------------------------------------------------------
module ccp_div_cell #(
  parameter int QB  = 13,
  parameter int BIT = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  logic                               v_in,
  input  ccp_pkg::sband_t                    sb_in,
  input  logic [ccp_pkg::DVW-1:0]            d_in,
  input  logic [1:0][ccp_pkg::NW-1:0]        rem_in,
  input  logic [1:0][QB-1:0]                 q_in,
  input  logic [1:0]                         neg_in,
  input  logic [1:0]                         sat_in,
  output logic                               v_out,
  output ccp_pkg::sband_t                    sb_out,
  output logic [ccp_pkg::DVW-1:0]            d_out,
  output logic [1:0][ccp_pkg::NW-1:0]        rem_out,
  output logic [1:0][QB-1:0]                 q_out,
  output logic [1:0]                         neg_out,
  output logic [1:0]                         sat_out
);
  import ccp_pkg::*;

  localparam int XW = NW + QB;

  logic [XW-1:0]        trial;
  logic [1:0][XW-1:0]   rx;
  logic [1:0]           fit;

  assign trial = XW'(d_in) << BIT;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      rx[i]  = XW'(rem_in[i]);
      fit[i] = (rx[i] >= trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_out  <= sb_in;
      d_out   <= d_in;
      neg_out <= neg_in;
      sat_out <= sat_in;
      for (int i = 0; i < 2; i++) begin
        rem_out[i] <= fit[i] ? NW'(rx[i] - trial) : rem_in[i];
        q_out[i]   <= fit[i] ? (q_in[i] | (QB'(1) << BIT)) : q_in[i];
      end
    end
  end

endmodule

@@ rtl/conic_curve_plotter_core.sv @@
// ----------------------------------------------------------------------------
// conic_curve_plotter_core
// Solves a Q16.16 conic for the other coordinate of each swept column or row.
// ----------------------------------------------------------------------------
// Takes one request per clock while the skid entry is empty and returns one
// result per request, in order, through eight set-up stages for b, c and the
// discriminant, a chain of 47 square-root cells (one root bit each) and Q divide
// cells, Q = clog2(MAX_SIDE + 1), that form the rounded quotient for both roots.
// A two-entry output buffer lets a request in while a result waits. The user must
// write registers only while the block is idle; the block does not enforce it.
module conic_curve_plotter_core #(
  parameter int MAX_SIDE = 4096
) (
  input logic      clk,
  input logic      rst,
  ccp_cfg_if.sink  cfg,
  ccp_req_if.sink  req,
  ccp_res_if.source res
);
  import ccp_pkg::*;

  localparam int QB   = $clog2(MAX_SIDE + 1);
  localparam int RW   = QB + 1;
  localparam int CMPW = ((RW > DIMW) ? RW : DIMW) + 2;
  localparam int XW   = NW + QB;

  logic signed [CW-1:0] coef_xx, coef_xy, coef_yy, coef_x, coef_y, coef_const;
  logic [DIMW-1:0]      image_width, image_height;

  logic                 en;
  logic                 skid_v, ov;
  result_t              skid, obuf, fin;

  logic                 fr_v;
  sband_t               fr_sb;
  logic [SQW-1:0]       fr_disc;

  logic                 sv   [SRW+1];
  sband_t               ssb  [SRW+1];
  logic [SQW-1:0]       srem [SRW+1];
  logic [SRW-1:0]       sq   [SRW+1];

  logic                 pr_v;
  sband_t               pr_sb;
  logic [DVW-1:0]       pr_d;
  logic [1:0][NW-1:0]   pr_n;
  logic signed [48:0]   sum [2];
  logic signed [48:0]   num [2];
  logic [CW-1:0]        lmag;
  logic [1:0]           pneg, psat;

  logic                 dv   [QB+1];
  sband_t               dsb  [QB+1];
  logic [DVW-1:0]       dd   [QB+1];
  logic [1:0][NW-1:0]   drem [QB+1];
  logic [1:0][QB-1:0]   dq   [QB+1];
  logic [1:0]           dneg [QB+1];
  logic [1:0]           dsat [QB+1];

  logic signed [RW-1:0]   r [2];
  logic signed [CMPW-1:0] rx [2];
  logic signed [CMPW-1:0] sx, sxm1;
  logic [2:0]             nb [2];

  // register file
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_xx      <= '0;
      coef_xy      <= '0;
      coef_yy      <= '0;
      coef_x       <= '0;
      coef_y       <= '0;
      coef_const   <= '0;
      image_width  <= DIMW'(4096);
      image_height <= DIMW'(4096);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_COEF_XX: coef_xx      <= $signed(cfg.data);
        REG_COEF_XY: coef_xy      <= $signed(cfg.data);
        REG_COEF_YY: coef_yy      <= $signed(cfg.data);
        REG_COEF_X:  coef_x       <= $signed(cfg.data);
        REG_COEF_Y:  coef_y       <= $signed(cfg.data);
        REG_COEF_C:  coef_const   <= $signed(cfg.data);
        REG_WIDTH:   image_width  <= cfg.data[DIMW-1:0];
        REG_HEIGHT:  image_height <= cfg.data[DIMW-1:0];
        default: ;
      endcase
    end
  end

  assign en        = !skid_v;
  assign req.ready = en;

  ccp_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk, .rst, .en,
    .in_v(req.valid),
    .op(req.op), .coord(req.coord), .color(req.pen_color),
    .coef_xx, .coef_xy, .coef_yy, .coef_x, .coef_y, .coef_const,
    .image_width, .image_height,
    .out_v(fr_v), .out_sb(fr_sb), .out_disc(fr_disc)
  );

  // square root chain, most significant bit first
  assign sv[0]   = fr_v;
  assign ssb[0]  = fr_sb;
  assign srem[0] = fr_disc;
  assign sq[0]   = '0;

  for (genvar j = 0; j < SRW; j++) begin : g_sqrt
    ccp_sqrt_cell #(.BIT(SRW - 1 - j)) u_cell (
      .clk, .rst, .en,
      .v_in(sv[j]), .sb_in(ssb[j]), .rem_in(srem[j]), .q_in(sq[j]),
      .v_out(sv[j+1]), .sb_out(ssb[j+1]), .rem_out(srem[j+1]), .q_out(sq[j+1])
    );
  end

  // rounding set-up: n = 2*num + den, d = 2*den with den made positive
  always_comb begin
    lmag   = ssb[SRW].lead[CW-1] ? CW'(-ssb[SRW].lead) : CW'(ssb[SRW].lead);
    sum[0] = 49'(ssb[SRW].b) + $signed({2'b00, sq[SRW]});
    sum[1] = 49'(ssb[SRW].b) - $signed({2'b00, sq[SRW]});
    for (int i = 0; i < 2; i++) begin
      num[i] = ssb[SRW].lead[CW-1] ? sum[i] : -sum[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pr_v <= 1'b0;
    end else if (en) begin
      pr_v <= sv[SRW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pr_sb <= ssb[SRW];
      pr_d  <= {lmag, 2'b00};
      for (int i = 0; i < 2; i++) begin
        pr_n[i] <= (NW'(num[i]) <<< 1) + NW'({lmag, 1'b0});
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      pneg[i] = pr_n[i][NW-1];
      psat[i] = (XW'(pr_n[i]) >= (XW'(pr_d) << QB));
    end
  end

  assign dv[0]   = pr_v;
  assign dsb[0]  = pr_sb;
  assign dd[0]   = pr_d;
  assign drem[0] = pr_n;
  assign dq[0]   = '0;
  assign dneg[0] = pneg;
  assign dsat[0] = psat;

  for (genvar j = 0; j < QB; j++) begin : g_div
    ccp_div_cell #(.QB(QB), .BIT(QB - 1 - j)) u_cell (
      .clk, .rst, .en,
      .v_in(dv[j]), .sb_in(dsb[j]), .d_in(dd[j]), .rem_in(drem[j]), .q_in(dq[j]),
      .neg_in(dneg[j]), .sat_in(dsat[j]),
      .v_out(dv[j+1]), .sb_out(dsb[j+1]), .d_out(dd[j+1]), .rem_out(drem[j+1]),
      .q_out(dq[j+1]), .neg_out(dneg[j+1]), .sat_out(dsat[j+1])
    );
  end

  // saturation, bounds mask and status
  always_comb begin
    sx   = $signed(CMPW'(dsb[QB].side));
    sxm1 = sx - CMPW'(1);
    for (int i = 0; i < 2; i++) begin
      priority if (dneg[QB][i]) begin
        r[i] = -RW'(1);
      end else if (dsat[QB][i] || (32'(dq[QB][i]) > MAX_SIDE)) begin
        r[i] = RW'(MAX_SIDE);
      end else begin
        r[i] = $signed({1'b0, dq[QB][i]});
      end
      rx[i]    = CMPW'(r[i]);
      nb[i][0] = (rx[i] >= 0) && (rx[i] < sx);
      nb[i][1] = (rx[i] >= 1) && (rx[i] < sx);
      nb[i][2] = (rx[i] >= 0) && (rx[i] < sxm1);
    end
    fin.pass_out   = dsb[QB].op;
    fin.coord_out  = dsb[QB].coord;
    fin.color_out  = dsb[QB].color;
    fin.root_low   = '0;
    fin.root_high  = '0;
    fin.write_mask = '0;
    priority if (dsb[QB].lead_zero) begin
      fin.status = ST_ZERO_LEAD;
    end else if (dsb[QB].disc_neg) begin
      fin.status = ST_NEG_DISC;
    end else begin
      fin.status     = ST_FOUND;
      fin.root_low   = ROW'(r[0]);
      fin.root_high  = ROW'(r[1]);
      fin.write_mask = {nb[1][2], nb[0][2], nb[1][1], nb[0][1], nb[1][0], nb[0][0]};
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      ov     <= 1'b0;
      skid_v <= 1'b0;
    end else begin
      if (!ov || res.ready) begin
        ov     <= skid_v || (en && dv[QB]);
        skid_v <= 1'b0;
      end else if (en && dv[QB]) begin
        skid_v <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!ov || res.ready) begin
      obuf <= skid_v ? skid : fin;
    end else if (en && dv[QB]) begin
      skid <= fin;
    end
  end

  assign res.valid      = ov;
  assign res.pass_out   = obuf.pass_out;
  assign res.coord_out  = obuf.coord_out;
  assign res.color_out  = obuf.color_out;
  assign res.root_low   = obuf.root_low;
  assign res.root_high  = obuf.root_high;
  assign res.write_mask = obuf.write_mask;
  assign res.status     = obuf.status;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> ov)
    else $error("skid entry held without output entry");
  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(ov && !res.ready))
    else $error("skid filled while output was free");
  a_no_roots: assert property (@(posedge clk) disable iff (rst)
    (ov && res.status != ST_FOUND) |->
      (res.write_mask == '0 && res.root_low == '0 && res.root_high == '0))
    else $error("roots reported without a solution");
  a_mask_nest: assert property (@(posedge clk) disable iff (rst)
    (ov && (res.write_mask[2] || res.write_mask[4])) |-> res.write_mask[0])
    else $error("neighbor pixel in bounds without the root itself");
`endif

endmodule

@@ test/tb_conic_curve_plotter_core.sv @@
// ----------------------------------------------------------------------------
// tb_conic_curve_plotter_core
// Self-checking bench for the conic plotter: directed and random sweep requests
// over directed and random conic settings, checked against an in-bench solver.
// ----------------------------------------------------------------------------
module tb_conic_curve_plotter_core;
  import ccp_pkg::*;

  localparam int SIDE_MAX = 4096;
  localparam int DRAIN    = 90;
  localparam int WD_LIMIT = 5000;

  typedef struct {
    logic          op;
    logic [11:0]   coord;
    logic [7:0]    color;
  } sweep_t;

  logic clk;
  logic rst;

  ccp_cfg_if cfg ();
  ccp_req_if req ();
  ccp_res_if res ();

  conic_curve_plotter_core #(.MAX_SIDE(SIDE_MAX)) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .req(req),
    .res(res)
  );

  longint  k_xx, k_xy, k_yy, k_x, k_y, k_c;
  int      img_w, img_h;
  sweep_t  sweep_q[$];
  result_t roots_q[$];
  int      errors;
  int      burst_left, gap_left;
  int      stall_left, run_left;
  int      quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t solve_sweep(logic op, logic [11:0] coord, logic [7:0] color);
    result_t r;
    longint lead, other, lin_u, lin_t, t, b, c, side;
    logic signed [127:0] disc, cand, s, num, den, n, d, q;
    longint r1, r2;
    r = '0;
    r.pass_out  = op;
    r.coord_out = coord;
    r.color_out = color;
    r.status    = ST_FOUND;
    t = longint'(coord);
    if (op == 1'b0) begin
      lead = k_yy; other = k_xx; lin_u = k_y; lin_t = k_x; side = img_h;
    end else begin
      lead = k_xx; other = k_yy; lin_u = k_x; lin_t = k_y; side = img_w;
    end
    if (side > SIDE_MAX) side = SIDE_MAX;
    b = lin_u + k_xy * t;
    c = k_c + t * (lin_t + other * t);
    if (lead == 0) begin
      r.status = ST_ZERO_LEAD;
      return r;
    end
    disc = 128'(b) * 128'(b) - 128'(4) * 128'(lead) * 128'(c);
    if (disc < 0) begin
      r.status = ST_NEG_DISC;
      return r;
    end
    s = 0;
    for (int i = 47; i >= 0; i--) begin
      cand = s | (128'sd1 <<< i);
      if (cand * cand <= disc) s = cand;
    end
    for (int k = 0; k < 2; k++) begin
      num = (k == 0) ? -(128'(b) + s) : -(128'(b) - s);
      den = 128'(2) * 128'(lead);
      if (den < 0) begin
        num = -num;
        den = -den;
      end
      n = 2 * num + den;
      d = 2 * den;
      q = n / d;
      if ((n % d) != 0 && n < 0) q = q - 1;
      if (q < -1) q = -1;
      if (q > SIDE_MAX) q = SIDE_MAX;
      if (k == 0) r1 = longint'(q);
      else r2 = longint'(q);
    end
    r.root_low  = r1[13:0];
    r.root_high = r2[13:0];
    r.write_mask[0] = (r1 >= 0 && r1 < side);
    r.write_mask[1] = (r2 >= 0 && r2 < side);
    r.write_mask[2] = (r1 >= 1 && r1 < side);
    r.write_mask[3] = (r2 >= 1 && r2 < side);
    r.write_mask[4] = (r1 >= 0 && r1 < side - 1);
    r.write_mask[5] = (r2 >= 0 && r2 < side - 1);
    return r;
  endfunction

  // sender: bursts with random gaps
  always @(posedge clk) begin
    sweep_t it;
    logic   v;
    if (rst) begin
      req.valid  <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (req.valid && req.ready) roots_q.push_back(solve_sweep(req.op, req.coord, req.pen_color));
      if (!req.valid || req.ready) begin
        v = 1'b0;
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (sweep_q.size() > 0) begin
          it = sweep_q.pop_front();
          v = 1'b1;
          req.op        <= it.op;
          req.coord     <= it.coord;
          req.pen_color <= it.color;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(0, 30);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
        req.valid <= v;
      end
    end
  end

  // receiver: stall pattern and compare
  always @(posedge clk) begin
    result_t e;
    if (rst) begin
      res.ready  <= 1'b0;
      stall_left <= 0;
      run_left   <= 0;
    end else begin
      if (res.valid && res.ready) begin
        if (roots_q.size() == 0) begin
          $error("unexpected result coord_out=%0d", res.coord_out);
          errors++;
        end else begin
          e = roots_q.pop_front();
          if (res.pass_out !== e.pass_out) begin
            $error("pass_out exp %0d got %0d", e.pass_out, res.pass_out); errors++;
          end
          if (res.coord_out !== e.coord_out) begin
            $error("coord_out exp %0d got %0d", e.coord_out, res.coord_out); errors++;
          end
          if (res.color_out !== e.color_out) begin
            $error("color_out exp %0d got %0d", e.color_out, res.color_out); errors++;
          end
          if (res.root_low !== e.root_low) begin
            $error("root_low exp %0d got %0d", $signed(e.root_low), $signed(res.root_low));
            errors++;
          end
          if (res.root_high !== e.root_high) begin
            $error("root_high exp %0d got %0d", $signed(e.root_high), $signed(res.root_high));
            errors++;
          end
          if (res.write_mask !== e.write_mask) begin
            $error("write_mask exp %b got %b", e.write_mask, res.write_mask); errors++;
          end
          if (res.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, res.status); errors++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        res.ready  <= 1'b0;
      end else if (run_left > 0) begin
        run_left  <= run_left - 1;
        res.ready <= 1'b1;
      end else begin
        run_left   <= $urandom_range(1, 40);
        stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        res.ready  <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (res.valid && res.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WD_LIMIT) begin
      $display("tb_conic_curve_plotter_core NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [IDXW-1:0] idx, logic [31:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_COEF_XX: k_xx = longint'($signed(val));
      REG_COEF_XY: k_xy = longint'($signed(val));
      REG_COEF_YY: k_yy = longint'($signed(val));
      REG_COEF_X:  k_x  = longint'($signed(val));
      REG_COEF_Y:  k_y  = longint'($signed(val));
      REG_COEF_C:  k_c  = longint'($signed(val));
      REG_WIDTH:   img_w = int'(val[12:0]);
      REG_HEIGHT:  img_h = int'(val[12:0]);
      default: ;
    endcase
  endtask

  task automatic load_conic(longint a, longint bx, longint cc, longint dd, longint ee,
                            longint ff, int w, int h);
    write_reg(REG_COEF_XX, a[31:0]);
    write_reg(REG_COEF_XY, bx[31:0]);
    write_reg(REG_COEF_YY, cc[31:0]);
    write_reg(REG_COEF_X, dd[31:0]);
    write_reg(REG_COEF_Y, ee[31:0]);
    write_reg(REG_COEF_C, ff[31:0]);
    write_reg(REG_WIDTH, 32'(w));
    write_reg(REG_HEIGHT, 32'(h));
    cfg.valid <= 1'b0;
  endtask

  task automatic drain_all();
    while (sweep_q.size() > 0 || req.valid || roots_q.size() > 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic add_sweep(logic op, int coord, logic [7:0] color);
    sweep_t it;
    it.op    = op;
    it.coord = coord[11:0];
    it.color = color;
    sweep_q.push_back(it);
  endtask

  function automatic longint pick_extreme();
    case ($urandom_range(0, 5))
      0: return -64'sd2147483648;
      1: return 64'sd2147483647;
      2: return 0;
      3: return 1;
      4: return -1;
      default: return longint'($signed(32'($urandom())));
    endcase
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 1;
      2: return 4096;
      3: return 8191;
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  initial begin
    longint a, cx, cy, rr, sg, bx;
    int     w, h, kind, span;
    rst = 1'b1;
    errors = 0;
    quiet_cycles = 0;
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data  = '0;
    req.valid = 1'b0;
    req.op = 1'b0;
    req.coord = '0;
    req.pen_color = '0;
    res.ready = 1'b0;
    k_xx = 0; k_xy = 0; k_yy = 0; k_x = 0; k_y = 0; k_c = 0;
    img_w = 4096;
    img_h = 4096;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: zero lead on both passes
    add_sweep(1'b0, 0, 8'h00);
    add_sweep(1'b1, 4095, 8'hff);
    add_sweep(1'b0, 4095, 8'h55);
    add_sweep(1'b1, 0, 8'haa);
    drain_all();

    // unit circle scaled: center (2048,2048), radius 1000, a = 1 raw
    load_conic(1, 0, 1, -4096, -4096, 2048*2048*2 - 1000*1000, 4096, 4096);
    add_sweep(1'b0, 2048, 8'h01);
    add_sweep(1'b1, 2048, 8'h02);
    add_sweep(1'b0, 1048, 8'h03);
    add_sweep(1'b1, 3048, 8'h04);
    add_sweep(1'b0, 0, 8'h05);
    add_sweep(1'b1, 4095, 8'h06);
    add_sweep(1'b0, 1100, 8'hfe);
    drain_all();

    // nearly flat lead: roots saturate high and low
    load_conic(1, 0, 1, -64'sd2147483648, 64'sd2147483647, 0, 1, 0);
    add_sweep(1'b0, 0, 8'h10);
    add_sweep(1'b1, 0, 8'h20);
    add_sweep(1'b0, 4095, 8'h30);
    add_sweep(1'b1, 4095, 8'h40);
    drain_all();

    // negative lead, small image
    load_conic(-3, 2, -3, 6*5, 6*5, -3*50 + 3*9, 8, 8);
    for (int i = 0; i < 6; i++) add_sweep(i[0], i, 8'(i * 37));
    drain_all();

    for (int p = 0; p < 10; p++) begin
      kind = p % 4;
      if (kind == 0 || kind == 3) begin
        w  = (kind == 3) ? $urandom_range(1, 16) : $urandom_range(1, 4096);
        h  = (kind == 3) ? $urandom_range(1, 16) : $urandom_range(1, 4096);
        a  = $urandom_range(1, 60);
        cx = $urandom_range(0, w);
        cy = $urandom_range(0, h);
        rr = (kind == 3) ? $urandom_range(1, 12) : $urandom_range(1, 1500);
        sg = $urandom_range(0, 1) ? 1 : -1;
        bx = (kind == 3) ? $signed($urandom_range(0, 2 * a)) - a : 0;
        load_conic(sg * a, sg * bx, sg * a, -sg * 2 * a * cx, -sg * 2 * a * cy,
                   sg * a * (cx * cx + cy * cy - rr * rr), w, h);
        span = int'(rr) + 2;
        for (int i = 0; i < 120; i++) begin
          if ($urandom_range(0, 4) == 0) begin
            add_sweep($urandom_range(0, 1), $urandom_range(0, 4095), $urandom_range(0, 255));
          end else if ($urandom_range(0, 1)) begin
            add_sweep(1'b0, int'(cx) - span + $urandom_range(0, 2 * span) & 12'hfff,
                      $urandom_range(0, 255));
          end else begin
            add_sweep(1'b1, int'(cy) - span + $urandom_range(0, 2 * span) & 12'hfff,
                      $urandom_range(0, 255));
          end
        end
      end else begin
        if (kind == 1)
          load_conic(longint'($signed(32'($urandom()))), longint'($signed(32'($urandom()))),
                     longint'($signed(32'($urandom()))), longint'($signed(32'($urandom()))),
                     longint'($signed(32'($urandom()))), longint'($signed(32'($urandom()))),
                     $urandom_range(0, 8191), $urandom_range(0, 8191));
        else
          load_conic(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                     pick_extreme(), pick_extreme(), pick_dim(), pick_dim());
        for (int i = 0; i < 120; i++)
          add_sweep($urandom_range(0, 1), $urandom_range(0, 4095), $urandom_range(0, 255));
      end
      drain_all();
    end

    if (errors == 0) begin
      $display("tb_conic_curve_plotter_core OK");
    end else begin
      $display("tb_conic_curve_plotter_core NOT OK");
    end
    $finish;
  end

endmodule
